FILE: rtl/core/pwl_pkg.sv
// Shared types and constants for the piecewise linear interpolator.
// Used by the slope divider and the top level; depends on nothing else.
package pwl_pkg;

    // Width of a Q16.16 value and its fraction.
    localparam int Q_W    = 32;
    localparam int FRAC_W = 16;

    // Request selector.
    localparam int REQ_W = 2;
    localparam logic [REQ_W-1:0] REQ_CLEAR  = 2'd0;
    localparam logic [REQ_W-1:0] REQ_APPEND = 2'd1;
    localparam logic [REQ_W-1:0] REQ_QUERY  = 2'd2;

    // Slope divider: a 32-bit magnitude shifted up by the fraction width,
    // divided by a 32-bit positive step in x.
    localparam int DIV_NUM_W = Q_W + FRAC_W;
    localparam int DIV_DEN_W = Q_W;
    localparam int DIV_STEPS = DIV_NUM_W;

    // Saturation limits of a Q16.16 value.
    localparam logic [Q_W-1:0] Q_MAX_BITS = 32'h7FFF_FFFF;
    localparam logic [Q_W-1:0] Q_MIN_BITS = 32'h8000_0000;

    typedef enum logic [1:0] {
        STAT_OK,
        STAT_FEW,
        STAT_FULL,
        STAT_ORDER
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_PREP,
        S_DIV,
        S_SCAN,
        S_FETCH,
        S_MUL,
        S_SUM,
        S_RESP
    } state_t;

endpackage

FILE: rtl/core/piecewise_linear_interpolator.sv
// Piecewise linear interpolator over a RAM table of ascending Q16.16 breakpoints.
// Depends on pwl_pkg, pwl_ram (three table RAMs) and pwl_div (slope divider).

// The block takes one request beat at a time and answers each with exactly one
// result beat. A clear empties the table, an append stores one breakpoint and,
// from the second point on, the slope of the new segment; a query returns
// y_left + slope * (x - x_left) on the segment found for x, extrapolating past
// either end, saturated to 32 bits. Errors come back in status with result_y
// zero: too few points for a query, table full, or an x that does not rise.
// A clear, an unused selector or a query on fewer than two points goes
// straight to the response state. An append is checked first; one past the
// first point that passes then waits on the bit-serial divider, which produces
// one of the 48 slope quotient bits per cycle. A query reads breakpoints from
// the x RAM, one per cycle through its single read port, until the first one
// at or above x is seen or the last stored one is read, then fetches the
// segment, multiplies and sums. in_stall is high while a request is being
// worked on; a finished result waits in the output register, and the next
// request beat is taken while it waits. A second finished result holds the
// block in its response state until the first one is taken. The tables hold
// no reset value: only entries below the point count are ever used.
module piecewise_linear_interpolator #(
    parameter int MAX_POINTS = 64
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic [pwl_pkg::REQ_W-1:0]       req_type,
    input  logic signed [pwl_pkg::Q_W-1:0]  x_value,
    input  logic signed [pwl_pkg::Q_W-1:0]  y_value,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic signed [pwl_pkg::Q_W-1:0]  result_y,
    output logic [1:0]                      status
);
    import pwl_pkg::*;

    localparam int ADDR_W = $clog2(MAX_POINTS);
    localparam int CNT_W  = $clog2(MAX_POINTS + 1);
    localparam int DIFF_W = Q_W + 1;
    localparam int PROD_W = Q_W + DIFF_W;
    localparam int SUM_W  = PROD_W - FRAC_W + 1;

    // Control state.
    state_t                   state_reg,     state_next;
    logic [CNT_W-1:0]         count_reg,     count_next;
    logic                     out_valid_reg, out_valid_next;

    // Working registers.
    logic signed [Q_W-1:0]    x_reg,         x_next;
    logic signed [Q_W-1:0]    y_reg,         y_next;
    logic signed [Q_W-1:0]    last_x_reg,    last_x_next;
    logic signed [Q_W-1:0]    last_y_reg,    last_y_next;
    logic signed [DIFF_W-1:0] dx_reg,        dx_next;
    logic signed [DIFF_W-1:0] dy_reg,        dy_next;
    logic                     neg_reg,       neg_next;
    logic [ADDR_W-1:0]        idx_reg,       idx_next;
    logic [ADDR_W-1:0]        seg_reg,       seg_next;
    logic signed [PROD_W-1:0] prod_reg,      prod_next;
    logic signed [Q_W-1:0]    yl_reg,        yl_next;
    logic [Q_W-1:0]           res_reg,       res_next;
    status_t                  stat_reg,      stat_next;
    logic [Q_W-1:0]           result_y_reg,  result_y_next;
    status_t                  status_reg,    status_next;

    // RAM and divider hookup.
    logic                     xy_we;
    logic [ADDR_W-1:0]        xy_waddr;
    logic                     slope_we;
    logic [ADDR_W-1:0]        slope_waddr;
    logic [Q_W-1:0]           slope_wdata;
    logic [ADDR_W-1:0]        x_raddr;
    logic [Q_W-1:0]           rd_x_bits;
    logic [Q_W-1:0]           rd_y_bits;
    logic [Q_W-1:0]           rd_slope_bits;
    logic signed [Q_W-1:0]    rd_x;
    logic signed [Q_W-1:0]    rd_y;
    logic signed [Q_W-1:0]    rd_slope;
    logic                     div_start;
    logic                     div_done;
    logic [DIV_NUM_W-1:0]     div_dividend;
    logic [DIV_NUM_W-1:0]     div_quotient;

    // Shared decode terms.
    logic                     in_fire;
    logic                     resp_load;
    logic                     dx_ok;
    logic [DIFF_W-1:0]        dy_mag;
    logic                     scan_hit;
    logic                     scan_last;
    logic signed [DIFF_W-1:0] q_diff;
    logic signed [SUM_W-1:0]  q_sum;

    assign rd_x     = $signed(rd_x_bits);
    assign rd_y     = $signed(rd_y_bits);
    assign rd_slope = $signed(rd_slope_bits);

    assign in_fire   = in_valid && !in_stall;
    assign resp_load = (state_reg == S_RESP) && (!out_valid_reg || !out_stall);
    assign dx_ok     = (dx_reg[DIFF_W-1] == 1'b0) && (dx_reg != '0);
    assign dy_mag    = dy_reg[DIFF_W-1] ? DIFF_W'(-dy_reg) : DIFF_W'(dy_reg);
    assign div_dividend = {dy_mag[Q_W-1:0], FRAC_W'(0)};
    assign scan_hit  = (x_reg <= rd_x);
    assign scan_last = (CNT_W'(idx_reg) == count_reg - CNT_W'(1));
    assign q_diff    = DIFF_W'(x_reg) - DIFF_W'(rd_x);
    assign q_sum     = SUM_W'(yl_reg) + SUM_W'($signed(prod_reg[PROD_W-1:FRAC_W]));

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    case (req_type)
                        REQ_APPEND: state_next = S_PREP;
                        REQ_QUERY:  state_next = (count_reg < CNT_W'(2)) ? S_RESP : S_SCAN;
                        default:    state_next = S_RESP;
                    endcase
                end
            end
            S_PREP:
            begin
                if (count_reg != CNT_W'(MAX_POINTS) && count_reg != '0 && dx_ok)
                begin
                    state_next = S_DIV;
                end
                else
                begin
                    state_next = S_RESP;
                end
            end
            S_DIV:   state_next = div_done ? S_RESP : S_DIV;
            S_SCAN:  state_next = (scan_hit || scan_last) ? S_FETCH : S_SCAN;
            S_FETCH: state_next = S_MUL;
            S_MUL:   state_next = S_SUM;
            S_SUM:   state_next = S_RESP;
            S_RESP:  state_next = resp_load ? S_IDLE : S_RESP;
            default: state_next = S_IDLE;
        endcase
    end

    // Control outputs toward the handshake, the RAMs and the divider.
    always_comb
    begin
        in_stall    = 1'b1;
        xy_we       = 1'b0;
        xy_waddr    = count_reg[ADDR_W-1:0];
        slope_we    = 1'b0;
        slope_waddr = ADDR_W'(count_reg - CNT_W'(1));
        x_raddr     = seg_reg;
        div_start   = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_stall = 1'b0;
                x_raddr  = '0;
            end
            S_PREP:
            begin
                // The first point needs no slope and goes straight in.
                if (count_reg == '0)
                begin
                    xy_we = 1'b1;
                end
                else if (count_reg != CNT_W'(MAX_POINTS) && dx_ok)
                begin
                    div_start = 1'b1;
                end
            end
            S_DIV:
            begin
                xy_we    = div_done;
                slope_we = div_done;
            end
            S_SCAN:
            begin
                x_raddr = idx_reg + ADDR_W'(1);
            end
            default:
            begin
                x_raddr = seg_reg;
            end
        endcase
    end

    // Slope from the divider: restore the sign, then saturate.
    always_comb
    begin
        if (neg_reg)
        begin
            slope_wdata = (div_quotient > DIV_NUM_W'(Q_MIN_BITS)) ? Q_MIN_BITS
                                                                  : -div_quotient[Q_W-1:0];
        end
        else
        begin
            slope_wdata = (div_quotient > DIV_NUM_W'(Q_MAX_BITS)) ? Q_MAX_BITS
                                                                  : div_quotient[Q_W-1:0];
        end
    end

    // Datapath.
    always_comb
    begin
        count_next     = count_reg;
        out_valid_next = out_valid_reg && out_stall;
        x_next         = x_reg;
        y_next         = y_reg;
        last_x_next    = last_x_reg;
        last_y_next    = last_y_reg;
        dx_next        = dx_reg;
        dy_next        = dy_reg;
        neg_next       = neg_reg;
        idx_next       = idx_reg;
        seg_next       = seg_reg;
        prod_next      = prod_reg;
        yl_next        = yl_reg;
        res_next       = res_reg;
        stat_next      = stat_reg;
        result_y_next  = result_y_reg;
        status_next    = status_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    x_next    = x_value;
                    y_next    = y_value;
                    dx_next   = DIFF_W'(x_value) - DIFF_W'(last_x_reg);
                    dy_next   = DIFF_W'(y_value) - DIFF_W'(last_y_reg);
                    idx_next  = '0;
                    res_next  = '0;
                    stat_next = STAT_OK;
                    if (req_type == REQ_CLEAR)
                    begin
                        count_next = '0;
                    end
                    else if (req_type == REQ_QUERY && count_reg < CNT_W'(2))
                    begin
                        stat_next = STAT_FEW;
                    end
                end
            end
            S_PREP:
            begin
                neg_next = dy_reg[DIFF_W-1];
                if (count_reg == CNT_W'(MAX_POINTS))
                begin
                    stat_next = STAT_FULL;
                end
                else if (count_reg == '0)
                begin
                    count_next  = CNT_W'(1);
                    last_x_next = x_reg;
                    last_y_next = y_reg;
                end
                else if (!dx_ok)
                begin
                    stat_next = STAT_ORDER;
                end
            end
            S_DIV:
            begin
                if (div_done)
                begin
                    count_next  = count_reg + CNT_W'(1);
                    last_x_next = x_reg;
                    last_y_next = y_reg;
                end
            end
            S_SCAN:
            begin
                idx_next = idx_reg + ADDR_W'(1);
                if (scan_hit)
                begin
                    seg_next = (idx_reg == '0) ? '0 : idx_reg - ADDR_W'(1);
                end
                else
                begin
                    seg_next = ADDR_W'(count_reg - CNT_W'(2));
                end
            end
            S_MUL:
            begin
                prod_next = rd_slope * q_diff;
                yl_next   = rd_y;
            end
            S_SUM:
            begin
                if (q_sum[SUM_W-1:Q_W-1] == {(SUM_W-Q_W+1){q_sum[SUM_W-1]}})
                begin
                    res_next = q_sum[Q_W-1:0];
                end
                else
                begin
                    res_next = q_sum[SUM_W-1] ? Q_MIN_BITS : Q_MAX_BITS;
                end
            end
            S_RESP:
            begin
                if (resp_load)
                begin
                    out_valid_next = 1'b1;
                    result_y_next  = res_reg;
                    status_next    = stat_reg;
                end
            end
            default:
            begin
                seg_next = seg_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg        <= x_next;
        y_reg        <= y_next;
        last_x_reg   <= last_x_next;
        last_y_reg   <= last_y_next;
        dx_reg       <= dx_next;
        dy_reg       <= dy_next;
        neg_reg      <= neg_next;
        idx_reg      <= idx_next;
        seg_reg      <= seg_next;
        prod_reg     <= prod_next;
        yl_reg       <= yl_next;
        res_reg      <= res_next;
        stat_reg     <= stat_next;
        result_y_reg <= result_y_next;
        status_reg   <= status_next;
    end

    pwl_ram #(
        .WIDTH (Q_W),
        .DEPTH (MAX_POINTS)
    ) u_break_x (
        .clk   (clk),
        .we    (xy_we),
        .waddr (xy_waddr),
        .wdata (x_reg),
        .raddr (x_raddr),
        .rdata (rd_x_bits)
    );

    pwl_ram #(
        .WIDTH (Q_W),
        .DEPTH (MAX_POINTS)
    ) u_break_y (
        .clk   (clk),
        .we    (xy_we),
        .waddr (xy_waddr),
        .wdata (y_reg),
        .raddr (seg_reg),
        .rdata (rd_y_bits)
    );

    pwl_ram #(
        .WIDTH (Q_W),
        .DEPTH (MAX_POINTS)
    ) u_slope (
        .clk   (clk),
        .we    (slope_we),
        .waddr (slope_waddr),
        .wdata (slope_wdata),
        .raddr (seg_reg),
        .rdata (rd_slope_bits)
    );

    pwl_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (dx_reg[Q_W-1:0]),
        .done     (div_done),
        .quotient (div_quotient)
    );

    assign out_valid = out_valid_reg;
    assign result_y  = $signed(result_y_reg);
    assign status    = status_reg;

    // The point count never passes the table depth.
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(MAX_POINTS))
        else $error("point count beyond table depth");

    // A slope only ever comes back while an append waits for it.
    a_div_owner: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> state_reg == S_DIV)
        else $error("divider finished outside an append");

    // The scan never reads past the stored points.
    a_scan_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_SCAN |-> CNT_W'(idx_reg) < count_reg)
        else $error("scan index beyond stored points");

    // A result beat appears only out of the response state.
    a_resp_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg) == S_RESP)
        else $error("result beat without a finished request");

endmodule

FILE: rtl/core/pwl_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Self-contained; no package is needed.
module pwl_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

FILE: rtl/core/pwl_div.sv
// Bit-serial restoring divider for the segment slope, one quotient bit a cycle.
// Depends on pwl_pkg for the operand widths.
module pwl_div (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    input  logic [pwl_pkg::DIV_NUM_W-1:0]  dividend,
    input  logic [pwl_pkg::DIV_DEN_W-1:0]  divisor,
    output logic                           done,
    output logic [pwl_pkg::DIV_NUM_W-1:0]  quotient
);
    import pwl_pkg::*;

    localparam int STEP_W = $clog2(DIV_STEPS);

    logic                  busy_reg,  busy_next;
    logic                  done_reg,  done_next;
    logic [STEP_W-1:0]     step_reg,  step_next;
    logic [DIV_NUM_W-1:0]  num_reg,   num_next;
    logic [DIV_DEN_W-1:0]  rem_reg,   rem_next;
    logic [DIV_DEN_W-1:0]  den_reg,   den_next;
    logic [DIV_DEN_W:0]    trial;

    // The dividend register fills with quotient bits from the bottom as it
    // shifts out at the top.
    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        step_next = step_reg;
        num_next  = num_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        trial     = {rem_reg, num_reg[DIV_NUM_W-1]} - {1'b0, den_reg};
        if (start)
        begin
            busy_next = 1'b1;
            step_next = '0;
            num_next  = dividend;
            rem_next  = '0;
            den_next  = divisor;
        end
        else if (busy_reg)
        begin
            if (trial[DIV_DEN_W] == 1'b0)
            begin
                rem_next = trial[DIV_DEN_W-1:0];
                num_next = {num_reg[DIV_NUM_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = {rem_reg[DIV_DEN_W-2:0], num_reg[DIV_NUM_W-1]};
                num_next = {num_reg[DIV_NUM_W-2:0], 1'b0};
            end
            step_next = step_reg + STEP_W'(1);
            if (step_reg == STEP_W'(DIV_STEPS - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        num_reg <= num_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
    end

    assign done     = done_reg;
    assign quotient = num_reg;

endmodule
